### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is disabled while reset is asserted.
`define SVP_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("svp assertion failed");

// Concurrent assertion that also holds across reset.
`define SVP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("svp assertion failed");

`endif

### rtl/svp_pkg.sv
// Types, constants and the sine table of the surface vertex projection.
`default_nettype none
package svp_pkg;

  localparam int DEF_GRID_ROWS     = 64;
  localparam int DEF_GRID_COLS     = 64;
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 320;
  localparam int DEF_CLAMP         = 0;

  localparam int INDEX_W  = 7;
  localparam int SAMPLE_W = 32;
  localparam int SCREEN_W = 16;
  localparam int DEPTH_W  = 32;
  localparam int ANGLE_W  = 12;
  localparam int EYE_W    = 14;
  localparam int STEP_W   = 16;
  localparam int GAIN_W   = 32;
  localparam int TRIG_W   = 17;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int SINE_N   = 901;
  localparam int SINE_W   = 16;
  localparam int SINE_A_W = 10;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef logic [INDEX_W-1:0]         index_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SCREEN_W-1:0] screen_t;
  typedef logic signed [DEPTH_W-1:0]  depth_t;
  typedef logic signed [ANGLE_W-1:0]  angle_t;
  typedef logic signed [TRIG_W-1:0]   trig_val_t;

  typedef enum logic [2:0] {
    REG_THETA   = 3'd0,
    REG_PHI     = 3'd1,
    REG_EYE     = 3'd2,
    REG_X_STEP  = 3'd3,
    REG_Y_STEP  = 3'd4,
    REG_Z_GAIN  = 3'd5,
    REG_VAL_MIN = 3'd6,
    REG_VAL_MAX = 3'd7
  } reg_idx_t;

  typedef struct packed {
    trig_val_t st;
    trig_val_t ct;
    trig_val_t sp;
    trig_val_t cp;
  } trig_t;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_N];

  // divide a series term by (2n)(2n+1), toward zero
  function automatic longint series_div(input longint t, input int n);
    unique case (n)
      1:       return t / 64'sd6;
      2:       return t / 64'sd20;
      3:       return t / 64'sd42;
      4:       return t / 64'sd72;
      5:       return t / 64'sd110;
      6:       return t / 64'sd156;
      default: return t / 64'sd210;
    endcase
  endfunction

  // Q30 Taylor series of sin(k tenths of a degree), rounded to Q.15
  function automatic logic [SINE_W-1:0] sine_entry(input int k);
    longint x;
    longint term;
    longint sum;
    x = longint'(k) * PI_Q30 / 64'sd1800;
    term = x;
    sum = x;
    for (int n = 1; n <= 7; n++) begin
      term = series_div(-term * x / ONE_Q30, n);
      sum = sum + term;
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) / 64'sd32768;
    if (sum > 64'sd32768) sum = 64'sd32768;
    return SINE_W'(sum);
  endfunction

  function automatic sine_rom_t sine_table();
    sine_rom_t t;
    for (int k = 0; k < SINE_N; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

### rtl/svp_if.sv
// Valid/ready channel interfaces for vertex beats and projected point beats.
`default_nettype none
interface svp_in_if;
  import svp_pkg::*;
  logic    valid;
  logic    ready;
  index_t  vertex_row;
  index_t  vertex_col;
  sample_t sample_up_left;
  sample_t sample_up_right;
  sample_t sample_low_left;
  sample_t sample_low_right;

  modport source (output valid, vertex_row, vertex_col, sample_up_left, sample_up_right,
                  sample_low_left, sample_low_right, input ready);
  modport sink (input valid, vertex_row, vertex_col, sample_up_left, sample_up_right,
                sample_low_left, sample_low_right, output ready);
endinterface

interface svp_out_if;
  import svp_pkg::*;
  logic    valid;
  logic    ready;
  screen_t screen_x;
  screen_t screen_y;
  depth_t  view_depth;
  logic    behind_eye;

  modport source (output valid, screen_x, screen_y, view_depth, behind_eye, input ready);
  modport sink (input valid, screen_x, screen_y, view_depth, behind_eye, output ready);
endinterface
`default_nettype wire

### rtl/svp_trig.sv
// Sine and cosine of both view angles, refreshed from the quarter-wave table.
`default_nettype none
module svp_trig (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svp_pkg::angle_t       theta,
  input  svp_pkg::angle_t       phi,
  input  logic                  restart,
  output svp_pkg::trig_t        trig,
  output logic                  busy
);
  import svp_pkg::*;

  typedef enum logic [1:0] {
    SEL_ST = 2'd0,
    SEL_CT = 2'd1,
    SEL_SP = 2'd2,
    SEL_CP = 2'd3
  } trig_sel_t;

  localparam logic [2:0] REFRESH_CYCLES = 3'd6;
  localparam sine_rom_t SINE_ROM = sine_table();

  trig_sel_t             sel_r;
  trig_sel_t             tgt_r;
  logic [SINE_W-1:0]     rom_q_r;
  logic                  neg_r;
  logic [2:0]            busy_r;
  trig_t                 trig_r;

  angle_t                ang;
  logic signed [13:0]    wrap;
  logic [11:0]           a_sin;
  logic [11:0]           a_cos;
  logic [11:0]           a_sel;
  logic [SINE_A_W-1:0]   addr;
  logic                  neg;
  trig_val_t             val;

  always_comb begin
    ang = (sel_r == SEL_SP || sel_r == SEL_CP) ? phi : theta;
    wrap = 14'(ang) + 14'sd3600;
    a_sin = (wrap >= 14'sd3600) ? 12'(wrap - 14'sd3600) : 12'(wrap);
    a_cos = (a_sin >= 12'd2700) ? (a_sin - 12'd2700) : (a_sin + 12'd900);
    a_sel = (sel_r == SEL_CT || sel_r == SEL_CP) ? a_cos : a_sin;
    priority if (a_sel <= 12'd900) begin
      addr = SINE_A_W'(a_sel);
      neg = 1'b0;
    end else if (a_sel <= 12'd1800) begin
      addr = SINE_A_W'(12'd1800 - a_sel);
      neg = 1'b0;
    end else if (a_sel <= 12'd2700) begin
      addr = SINE_A_W'(a_sel - 12'd1800);
      neg = 1'b1;
    end else begin
      addr = SINE_A_W'(12'd3600 - a_sel);
      neg = 1'b1;
    end
    val = neg_r ? -trig_val_t'({1'b0, rom_q_r}) : trig_val_t'({1'b0, rom_q_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= SEL_ST;
      busy_r <= REFRESH_CYCLES;
    end else begin
      sel_r <= trig_sel_t'(sel_r + 2'd1);
      if (restart) begin
        busy_r <= REFRESH_CYCLES;
      end else if (busy_r != 3'd0) begin
        busy_r <= busy_r - 3'd1;
      end
    end
  end

  // table read, then write the result into its slot in the following cycle
  always_ff @(posedge clk) begin
    rom_q_r <= SINE_ROM[addr];
    neg_r <= neg;
    tgt_r <= sel_r;
    unique case (tgt_r)
      SEL_ST: trig_r.st <= val;
      SEL_CT: trig_r.ct <= val;
      SEL_SP: trig_r.sp <= val;
      SEL_CP: trig_r.cp <= val;
    endcase
  end

  assign trig = trig_r;
  assign busy = (busy_r != 3'd0);

endmodule
`default_nettype wire

### rtl/svp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none
module svp_div #(
  parameter int NUM_W = 63,
  parameter int DEN_W = 45,
  parameter int QUO_W = 17
) (
  input  logic             clk,
  input  logic [QUO_W:0]   en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);
  localparam int SW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [SW-1:0]    rem_r [QUO_W+1];
  logic [DEN_W-1:0] den_r [QUO_W+1];
  logic [QUO_W-1:0] quo_r [QUO_W+1];
  logic             ovf_r [QUO_W+1];

  // quotient does not fit: flag it and let the result saturate
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= SW'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= SW'(num) >= (SW'(den) << QUO_W);
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    localparam int B = QUO_W - k;
    logic [SW-1:0] trial;
    logic          ge;
    assign trial = SW'(den_r[k-1]) << B;
    assign ge = rem_r[k-1] >= trial;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge ? (rem_r[k-1] - trial) : rem_r[k-1];
        den_r[k] <= den_r[k-1];
        quo_r[k] <= quo_r[k-1] | (QUO_W'(ge) << B);
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo = quo_r[QUO_W];
  assign ovf = ovf_r[QUO_W];

endmodule
`default_nettype wire

### rtl/surface_vertex_projection.sv
// Top level: grid vertex to perspective screen point, fully pipelined.
// An accepted vertex beat passes stages A to H, the divider and the output stage.
// Throughput: one vertex per cycle outside an angle refresh; each stage holds on
// its own when the next is full. The sine/cosine refresh of the angle table port
// keeps in ready low after reset and after every register write.
// Reset (rst_n, synchronous) clears the pipeline valids and loads the register defaults.
`default_nettype none
module surface_vertex_projection #(
  parameter int GRID_ROWS      = svp_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS      = svp_pkg::DEF_GRID_COLS,
  parameter int SCREEN_WIDTH   = svp_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT  = svp_pkg::DEF_SCREEN_HEIGHT,
  parameter int CLAMP_TO_RANGE = svp_pkg::DEF_CLAMP
) (
  input  logic                            clk,
  input  logic                            rst_n,
  svp_in_if.sink                          in_bus,
  svp_out_if.source                       out_bus,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [svp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [svp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [svp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import svp_pkg::*;

  localparam int QUO_W  = 17;
  localparam int NPRE   = 8;
  localparam int NS     = NPRE + QUO_W + 2;
  localparam int RC_W   = 13;
  localparam int D01_W  = 36;
  localparam int P1_W   = 54;
  localparam int X1_W   = P1_W - 15;
  localparam int D2_W   = 41;
  localparam int P2_W   = 59;
  localparam int E_W    = P2_W - 15;
  localparam int DEN_W  = 46;
  localparam int NX_W   = X1_W + EYE_W + 1;
  localparam int NY_W   = E_W + EYE_W + 1;
  localparam int NUM_W  = NY_W + 4;
  localparam int DIV_D_W = DEN_W - 1;

  localparam logic [10:0]        ROWS_C = 11'(GRID_ROWS);
  localparam logic [10:0]        COLS_C = 11'(GRID_COLS);
  localparam logic signed [18:0] CX     = 19'(SCREEN_WIDTH * 8);
  localparam logic signed [18:0] CY     = 19'(SCREEN_HEIGHT * 8);
  localparam logic [50:0]        DEPTH_LIMIT = 51'h000FFFFFFFFFF;

  typedef struct packed {
    logic   behind;
    logic   x_neg;
    logic   y_neg;
    logic   ex_pos;
    logic   ex_neg;
    logic   ey_pos;
    logic   ey_neg;
    depth_t depth;
  } side_t;

  // ---------------- configuration registers ----------------
  angle_t                     theta_r;
  angle_t                     phi_r;
  logic [EYE_W-1:0]           eye_r;
  logic [STEP_W-1:0]          x_step_r;
  logic [STEP_W-1:0]          y_step_r;
  logic [GAIN_W-1:0]          z_gain_r;
  sample_t                    vmin_r;
  sample_t                    vmax_r;
  logic                       cfg_we;
  reg_idx_t                   cfg_idx;

  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_r <= -12'sd300;
      phi_r <= 12'sd720;
      eye_r <= 14'd1000;
      x_step_r <= 16'd256;
      y_step_r <= 16'd256;
      z_gain_r <= 32'd65536;
      vmin_r <= 32'sd0;
      vmax_r <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_THETA:   theta_r <= cfg_pwdata[ANGLE_W-1:0];
        REG_PHI:     phi_r <= cfg_pwdata[ANGLE_W-1:0];
        REG_EYE:     eye_r <= cfg_pwdata[EYE_W-1:0];
        REG_X_STEP:  x_step_r <= cfg_pwdata[STEP_W-1:0];
        REG_Y_STEP:  y_step_r <= cfg_pwdata[STEP_W-1:0];
        REG_Z_GAIN:  z_gain_r <= cfg_pwdata[GAIN_W-1:0];
        REG_VAL_MIN: vmin_r <= cfg_pwdata[SAMPLE_W-1:0];
        REG_VAL_MAX: vmax_r <= cfg_pwdata[SAMPLE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_THETA:   cfg_prdata = {20'b0, theta_r};
      REG_PHI:     cfg_prdata = {20'b0, phi_r};
      REG_EYE:     cfg_prdata = {18'b0, eye_r};
      REG_X_STEP:  cfg_prdata = {16'b0, x_step_r};
      REG_Y_STEP:  cfg_prdata = {16'b0, y_step_r};
      REG_Z_GAIN:  cfg_prdata = z_gain_r;
      REG_VAL_MIN: cfg_prdata = vmin_r;
      REG_VAL_MAX: cfg_prdata = vmax_r;
    endcase
  end

  // ---------------- sine / cosine ----------------
  trig_t trig;
  logic  trig_busy;

  svp_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .theta   (theta_r),
    .phi     (phi_r),
    .restart (cfg_we),
    .trig    (trig),
    .busy    (trig_busy)
  );

  // ---------------- stage valids and enables ----------------
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  logic          in_acc;

  assign en[NS-1] = !v_r[NS-1] || out_bus.ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  assign in_bus.ready = en[0] && !trig_busy;
  assign in_acc = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_acc;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // ---------------- stage A: vertex height ----------------
  logic [10:0]            r_ext;
  logic [10:0]            c_ext;
  logic [10:0]            r_cl;
  logic [10:0]            c_cl;
  logic                   at_top;
  logic                   at_bot;
  logic                   at_left;
  logic                   at_right;
  logic signed [32:0]     sum_lo;
  logic signed [32:0]     sum_up;
  logic signed [32:0]     sum_l;
  logic signed [32:0]     sum_r;
  logic signed [33:0]     sum_all;
  sample_t                h_nxt;
  logic signed [RC_W-1:0] rr_nxt;
  logic signed [RC_W-1:0] cc_nxt;
  sample_t                h_r;
  logic signed [RC_W-1:0] rr_r;
  logic signed [RC_W-1:0] cc_r;

  always_comb begin
    r_ext = {4'b0, in_bus.vertex_row};
    c_ext = {4'b0, in_bus.vertex_col};
    r_cl = (r_ext > ROWS_C) ? ROWS_C : r_ext;
    c_cl = (c_ext > COLS_C) ? COLS_C : c_ext;
    at_top = (r_cl == 11'd0);
    at_bot = (r_cl == ROWS_C);
    at_left = (c_cl == 11'd0);
    at_right = (c_cl == COLS_C);
    sum_lo = 33'(in_bus.sample_low_left) + 33'(in_bus.sample_low_right);
    sum_up = 33'(in_bus.sample_up_left) + 33'(in_bus.sample_up_right);
    sum_l = 33'(in_bus.sample_up_right) + 33'(in_bus.sample_low_right);
    sum_r = 33'(in_bus.sample_up_left) + 33'(in_bus.sample_low_left);
    sum_all = 34'(sum_lo) + 34'(sum_up);
    priority if (at_top && at_left) h_nxt = in_bus.sample_low_right;
    else if (at_top && at_right)    h_nxt = in_bus.sample_low_left;
    else if (at_bot && at_left)     h_nxt = in_bus.sample_up_right;
    else if (at_bot && at_right)    h_nxt = in_bus.sample_up_left;
    else if (at_top)                h_nxt = 32'(sum_lo >>> 1);
    else if (at_bot)                h_nxt = 32'(sum_up >>> 1);
    else if (at_left)               h_nxt = 32'(sum_l >>> 1);
    else if (at_right)              h_nxt = 32'(sum_r >>> 1);
    else                            h_nxt = 32'(sum_all >>> 2);
    rr_nxt = RC_W'({r_cl, 1'b0}) - RC_W'(GRID_ROWS);
    cc_nxt = RC_W'({c_cl, 1'b0}) - RC_W'(GRID_COLS);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h_r <= h_nxt;
      rr_r <= rr_nxt;
      cc_r <= cc_nxt;
    end
  end

  // ---------------- stage B: optional clamp, depth offset, plane position ------------
  sample_t                 hc;
  logic signed [34:0]      diff;
  logic [33:0]             a_nxt;
  logic signed [RC_W+16:0] px;
  logic signed [RC_W+16:0] py;
  logic [33:0]             a_r;
  logic                    dneg_r;
  logic signed [D01_W-1:0] d0_r;
  logic signed [D01_W-1:0] d1_r;

  if (CLAMP_TO_RANGE != 0) begin : g_clamp
    sample_t hmax;
    assign hmax = (h_r > vmax_r) ? vmax_r : h_r;
    assign hc = (hmax < vmin_r) ? vmin_r : hmax;
  end else begin : g_noclamp
    assign hc = h_r;
  end

  always_comb begin
    diff = (35'(hc) <<< 1) - 35'(vmin_r) - 35'(vmax_r);
    a_nxt = diff[34] ? 34'(-diff) : diff[33:0];
    px = cc_r * signed'({1'b0, x_step_r});
    py = rr_r * signed'({1'b0, y_step_r});
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a_r <= a_nxt;
      dneg_r <= diff[34];
      d0_r <= D01_W'(px) <<< 7;
      d1_r <= D01_W'(py) <<< 7;
    end
  end

  // ---------------- stage C: gain products, first rotation products ----------------
  logic [49:0]            hi_r;
  logic [49:0]            lo_r;
  logic                   dneg_c_r;
  logic signed [P1_W-1:0] pa_r;
  logic signed [P1_W-1:0] pb_r;
  logic signed [P1_W-1:0] pc_r;
  logic signed [P1_W-1:0] pd_r;
  logic signed [P1_W-1:0] pa;
  logic signed [P1_W-1:0] pb;
  logic signed [P1_W-1:0] pc;
  logic signed [P1_W-1:0] pd;

  assign pa = trig.ct * d0_r;
  assign pb = trig.st * d1_r;
  assign pc = trig.ct * d1_r;
  assign pd = trig.st * d0_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hi_r <= a_r * z_gain_r[31:16];
      lo_r <= a_r * z_gain_r[15:0];
      dneg_c_r <= dneg_r;
      pa_r <= pa;
      pb_r <= pb;
      pc_r <= pc;
      pd_r <= pd;
    end
  end

  // ---------------- stage D: depth scale, first rotation sums ----------------
  logic [50:0]            mag;
  logic [50:0]            mag_sat;
  logic signed [P1_W-1:0] sx1;
  logic signed [P1_W-1:0] sy1;
  logic signed [X1_W-1:0] x1_r;
  logic signed [X1_W-1:0] y1_r;
  logic signed [D2_W-1:0] d2_r;

  always_comb begin
    mag = 51'(hi_r >> 1) + 51'((51'({hi_r[0], 16'b0}) + 51'(lo_r)) >> 17);
    mag_sat = (mag > DEPTH_LIMIT) ? DEPTH_LIMIT : mag;
    sx1 = pa_r + pb_r + P1_W'(16384);
    sy1 = pc_r - pd_r + P1_W'(16384);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x1_r <= X1_W'(sx1 >>> 15);
      y1_r <= X1_W'(sy1 >>> 15);
      d2_r <= dneg_c_r ? -signed'({1'b0, mag_sat[39:0]}) : signed'({1'b0, mag_sat[39:0]});
    end
  end

  // ---------------- stage E: second rotation products ----------------
  logic signed [P2_W-1:0] qa;
  logic signed [P2_W-1:0] qb;
  logic signed [P2_W-1:0] qc;
  logic signed [P2_W-1:0] qd;
  logic signed [P2_W-1:0] qa_r;
  logic signed [P2_W-1:0] qb_r;
  logic signed [P2_W-1:0] qc_r;
  logic signed [P2_W-1:0] qd_r;
  logic signed [X1_W-1:0] ex_e_r;

  assign qa = trig.cp * y1_r;
  assign qb = trig.sp * d2_r;
  assign qc = trig.sp * y1_r;
  assign qd = trig.cp * d2_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      qa_r <= qa;
      qb_r <= qb;
      qc_r <= qc;
      qd_r <= qd;
      ex_e_r <= x1_r;
    end
  end

  // ---------------- stage F: second rotation sums ----------------
  logic signed [P2_W-1:0] sey;
  logic signed [P2_W-1:0] sez;
  logic signed [X1_W-1:0] ex_r;
  logic signed [E_W-1:0]  ey_r;
  logic signed [E_W-1:0]  ez_r;

  assign sey = qa_r - qb_r + P2_W'(16384);
  assign sez = qc_r + qd_r + P2_W'(16384);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      ex_r <= ex_e_r;
      ey_r <= E_W'(sey >>> 15);
      ez_r <= E_W'(sez >>> 15);
    end
  end

  // ---------------- stage G: perspective numerators and denominator ----------------
  logic signed [EYE_W:0]   z0_s;
  logic signed [NX_W-1:0]  nx;
  logic signed [NY_W-1:0]  ny;
  logic signed [NX_W-1:0]  nx_g_r;
  logic signed [NY_W-1:0]  ny_g_r;
  logic signed [DEN_W-1:0] den_g_r;
  logic signed [E_W-1:0]   ez_g_r;
  logic                    ex_pos_g_r;
  logic                    ex_neg_g_r;
  logic                    ey_pos_g_r;
  logic                    ey_neg_g_r;

  assign z0_s = signed'({1'b0, eye_r});
  assign nx = ex_r * z0_s;
  assign ny = ey_r * z0_s;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      nx_g_r <= nx;
      ny_g_r <= ny;
      den_g_r <= signed'(DEN_W'({eye_r, 16'b0})) - DEN_W'(ez_r);
      ez_g_r <= ez_r;
      ex_pos_g_r <= (ex_r > 0);
      ex_neg_g_r <= ex_r[X1_W-1];
      ey_pos_g_r <= (ey_r > 0);
      ey_neg_g_r <= ey_r[E_W-1];
    end
  end

  // ---------------- stage H: divider operands ----------------
  logic [NUM_W-1:0]   mx;
  logic [NUM_W-1:0]   my;
  logic [DIV_D_W-1:0] dpos;
  side_t              side_nxt;
  logic [NUM_W-1:0]   nx_h_r;
  logic [NUM_W-1:0]   ny_h_r;
  logic [DIV_D_W-1:0] den_h_r;
  side_t              side_r [QUO_W+2];

  always_comb begin
    mx = NUM_W'(nx_g_r[NX_W-1] ? 64'(-nx_g_r) : 64'(nx_g_r)) << 4;
    my = NUM_W'(ny_g_r[NY_W-1] ? 64'(-ny_g_r) : 64'(ny_g_r)) << 4;
    dpos = den_g_r[DIV_D_W-1:0];
    side_nxt.behind = den_g_r[DEN_W-1] || (den_g_r == '0);
    side_nxt.x_neg = nx_g_r[NX_W-1];
    side_nxt.y_neg = ny_g_r[NY_W-1];
    side_nxt.ex_pos = ex_pos_g_r;
    side_nxt.ex_neg = ex_neg_g_r;
    side_nxt.ey_pos = ey_pos_g_r;
    side_nxt.ey_neg = ey_neg_g_r;
    if (ez_g_r > E_W'(32'sh7FFFFFFF)) side_nxt.depth = 32'sh7FFFFFFF;
    else if (ez_g_r < -E_W'(33'sh080000000)) side_nxt.depth = 32'sh80000000;
    else side_nxt.depth = ez_g_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[NPRE-1]) begin
      nx_h_r <= mx + NUM_W'(dpos >> 1);
      ny_h_r <= my + NUM_W'(dpos >> 1);
      den_h_r <= dpos;
      side_r[0] <= side_nxt;
    end
    for (int j = 1; j < QUO_W + 2; j++) begin
      if (en[NPRE-1+j]) side_r[j] <= side_r[j-1];
    end
  end

  // ---------------- divider stages ----------------
  logic [QUO_W-1:0] qx;
  logic [QUO_W-1:0] qy;
  logic             ovx;
  logic             ovy;

  svp_div #(.NUM_W(NUM_W), .DEN_W(DIV_D_W), .QUO_W(QUO_W)) u_div_x (
    .clk (clk),
    .en  (en[NPRE+QUO_W:NPRE]),
    .num (nx_h_r),
    .den (den_h_r),
    .quo (qx),
    .ovf (ovx)
  );

  svp_div #(.NUM_W(NUM_W), .DEN_W(DIV_D_W), .QUO_W(QUO_W)) u_div_y (
    .clk (clk),
    .en  (en[NPRE+QUO_W:NPRE]),
    .num (ny_h_r),
    .den (den_h_r),
    .quo (qy),
    .ovf (ovy)
  );

  // ---------------- output stage ----------------
  function automatic screen_t sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) return 16'sh7FFF;
    if (v < -19'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic screen_t place(input logic behind, input logic e_pos, input logic e_neg,
                                    input logic ovf, input logic neg,
                                    input logic [QUO_W-1:0] q,
                                    input logic signed [18:0] centre);
    logic signed [18:0] qs;
    qs = neg ? -signed'(19'(q)) : signed'(19'(q));
    if (behind) begin
      if (e_pos) return 16'sh7FFF;
      if (e_neg) return 16'sh8000;
      return sat16(centre);
    end
    if (ovf) return neg ? 16'sh8000 : 16'sh7FFF;
    return sat16(qs + centre);
  endfunction

  side_t   so;
  screen_t sx_r;
  screen_t sy_r;
  depth_t  depth_r;
  logic    behind_r;

  assign so = side_r[QUO_W+1];

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      sx_r <= place(so.behind, so.ex_pos, so.ex_neg, ovx, so.x_neg, qx, CX);
      sy_r <= place(so.behind, so.ey_pos, so.ey_neg, ovy, so.y_neg, qy, CY);
      depth_r <= so.depth;
      behind_r <= so.behind;
    end
  end

  assign out_bus.valid = v_r[NS-1];
  assign out_bus.screen_x = sx_r;
  assign out_bus.screen_y = sy_r;
  assign out_bus.view_depth = depth_r;
  assign out_bus.behind_eye = behind_r;

endmodule
`default_nettype wire

### rtl/svp_checker.sv
// Port-level checker for the surface vertex projection, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module svp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] screen_x,
  input logic [15:0] screen_y,
  input logic [31:0] view_depth,
  input logic        behind_eye,
  input logic        cfg_write
);

  // a stalled result beat holds
  `SVP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y) && $stable(view_depth) && $stable(behind_eye))

  // no result beat right after reset
  `SVP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // behind the eye means depth at or past the eye, never negative
  `SVP_ASSERT(a_behind_depth, clk, rst_n, out_valid && behind_eye |-> !view_depth[31])

  // angle refresh blocks input after a register write
  `SVP_ASSERT(a_cfg_refresh, clk, rst_n, cfg_write |=> !in_ready)

endmodule

bind surface_vertex_projection svp_checker u_svp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .screen_x   (out_bus.screen_x),
  .screen_y   (out_bus.screen_y),
  .view_depth (out_bus.view_depth),
  .behind_eye (out_bus.behind_eye),
  .cfg_write  (cfg_psel && cfg_penable && cfg_pwrite)
);
`default_nettype wire

### test/surface_vertex_projection_tb.sv
// Self-checking testbench for the surface vertex projection pipeline.
`default_nettype none
module surface_vertex_projection_tb;
  import svp_pkg::*;

  localparam int ROWS = DEF_GRID_ROWS;
  localparam int COLS = DEF_GRID_COLS;
  localparam int SCR_W = DEF_SCREEN_WIDTH;
  localparam int SCR_H = DEF_SCREEN_HEIGHT;
  localparam int CLAMP = DEF_CLAMP;
  localparam int PIPE_LAT = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 125;

  typedef struct {
    index_t  row;
    index_t  col;
    sample_t ul;
    sample_t ur;
    sample_t ll;
    sample_t lr;
  } vertex_t;

  typedef struct {
    screen_t sx;
    screen_t sy;
    depth_t  depth;
    logic    behind;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  svp_in_if  in_bus();
  svp_out_if out_bus();

  surface_vertex_projection u_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.vertex_row = '0;
    in_bus.vertex_col = '0;
    in_bus.sample_up_left = '0;
    in_bus.sample_up_right = '0;
    in_bus.sample_low_left = '0;
    in_bus.sample_low_right = '0;
    out_bus.ready = 1'b0;
  end

  // shadow of the register file
  longint theta_sh, phi_sh, eye_sh, xstep_sh, ystep_sh, gain_sh, vmin_sh, vmax_sh;
  longint sine_q15 [SINE_N];

  vertex_t pending_vertices [$];
  point_t  expected_points [$];
  int errors = 0;
  int n_vertices = 0;
  int n_points = 0;
  int n_behind = 0;
  int n_writes = 0;
  bit in_taken = 1'b0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH point %0d %s: got %0d expected %0d", n_points, what, got, want);
  endtask

  function automatic void build_sine();
    longint x, term, acc;
    for (int k = 0; k < SINE_N; k++) begin
      x = longint'(k) * 64'sd3373259426 / 64'sd1800;
      term = x;
      acc = x;
      for (int n = 1; n <= 7; n++) begin
        term = (-term * x / 64'sd1073741824) / (longint'(2 * n) * longint'(2 * n + 1));
        acc += term;
      end
      if (acc < 0) acc = 0;
      acc = (acc + 16384) / 32768;
      sine_q15[k] = (acc > 32768) ? 64'sd32768 : acc;
    end
  endfunction

  function automatic longint sine_of(input longint a);
    if (a <= 900) return sine_q15[a];
    if (a <= 1800) return sine_q15[1800 - a];
    if (a <= 2700) return -sine_q15[a - 1800];
    return -sine_q15[3600 - a];
  endfunction

  function automatic void angle_trig(input longint t, output longint s, output longint c);
    longint a;
    a = (t + 7200) % 3600;
    s = sine_of(a);
    c = sine_of((a + 900) % 3600);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint to_screen(input longint e, input longint z0, input longint den,
                                       input longint centre);
    longint num, q;
    if (den <= 0) begin
      if (e > 0) return 32767;
      if (e < 0) return -32768;
      return clip(centre, -32768, 32767);
    end
    num = e * z0 * 16;
    if (num >= 0) q = (num + den / 2) / den;
    else q = -((-num + den / 2) / den);
    return clip(q + centre, -32768, 32767);
  endfunction

  function automatic point_t project_vertex(input vertex_t v);
    point_t p;
    longint r, c, ul, ur, ll, lr, h, diff, d0, d1, d2;
    longint st, ct, sp, cp, x1, y1, ex, ey, ez, den;
    longint unsigned a, hi, lo, mag;
    bit top, bot, left, right;
    r = v.row;
    c = v.col;
    ul = longint'(v.ul);
    ur = longint'(v.ur);
    ll = longint'(v.ll);
    lr = longint'(v.lr);
    if (r > ROWS) r = ROWS;
    if (c > COLS) c = COLS;
    top = (r == 0);
    bot = (r == ROWS);
    left = (c == 0);
    right = (c == COLS);
    if (top && left) h = lr;
    else if (top && right) h = ll;
    else if (bot && left) h = ur;
    else if (bot && right) h = ul;
    else if (top) h = (ll + lr) >>> 1;
    else if (bot) h = (ul + ur) >>> 1;
    else if (left) h = (ur + lr) >>> 1;
    else if (right) h = (ul + ll) >>> 1;
    else h = (ul + ur + ll + lr) >>> 2;
    if (CLAMP != 0) begin
      if (h > vmax_sh) h = vmax_sh;
      if (h < vmin_sh) h = vmin_sh;
    end
    d0 = (2 * c - COLS) * xstep_sh * 128;
    d1 = (2 * r - ROWS) * ystep_sh * 128;
    diff = 2 * h - vmin_sh - vmax_sh;
    a = (diff < 0) ? -diff : diff;
    hi = a * (gain_sh >> 16);
    lo = a * (gain_sh & 64'hFFFF);
    mag = (hi >> 1) + ((((hi & 1) << 16) + lo) >> 17);
    if (mag > 64'd1099511627775) mag = 64'd1099511627775;
    d2 = (diff < 0) ? -longint'(mag) : longint'(mag);
    angle_trig(theta_sh, st, ct);
    angle_trig(phi_sh, sp, cp);
    x1 = (ct * d0 + st * d1 + 16384) >>> 15;
    y1 = (ct * d1 - st * d0 + 16384) >>> 15;
    ex = x1;
    ey = (cp * y1 - sp * d2 + 16384) >>> 15;
    ez = (sp * y1 + cp * d2 + 16384) >>> 15;
    den = eye_sh * 65536 - ez;
    p.sx = screen_t'(to_screen(ex, eye_sh, den, SCR_W * 8));
    p.sy = screen_t'(to_screen(ey, eye_sh, den, SCR_H * 8));
    p.depth = depth_t'(clip(ez, -64'sd2147483648, 64'sd2147483647));
    p.behind = (den <= 0);
    return p;
  endfunction

  function automatic void shadow_write(input reg_idx_t r, input logic [31:0] v);
    case (r)
      REG_THETA:   theta_sh = longint'($signed(v[11:0]));
      REG_PHI:     phi_sh = longint'($signed(v[11:0]));
      REG_EYE:     eye_sh = longint'(v[13:0]);
      REG_X_STEP:  xstep_sh = longint'(v[15:0]);
      REG_Y_STEP:  ystep_sh = longint'(v[15:0]);
      REG_Z_GAIN:  gain_sh = longint'({32'd0, v});
      REG_VAL_MIN: vmin_sh = longint'($signed(v));
      REG_VAL_MAX: vmax_sh = longint'($signed(v));
      default: ;
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(int'(r) * 4);
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    shadow_write(r, v);
    n_writes++;
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() != 0 || expected_points.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'($urandom());
      1: return sample_t'(32'h8000_0000);
      2: return sample_t'(32'h7FFF_FFFF);
      default: return sample_t'($signed($urandom_range(0, 2 * 262144)) - 262144);
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.row = ($urandom_range(0, 15) == 0) ? index_t'($urandom()) : index_t'($urandom_range(0, ROWS));
    v.col = ($urandom_range(0, 15) == 0) ? index_t'($urandom()) : index_t'($urandom_range(0, COLS));
    if ($urandom_range(0, 7) == 0) v.row = ($urandom_range(0, 1) != 0) ? index_t'(ROWS) : '0;
    if ($urandom_range(0, 7) == 0) v.col = ($urandom_range(0, 1) != 0) ? index_t'(COLS) : '0;
    v.ul = rand_sample();
    v.ur = rand_sample();
    v.ll = rand_sample();
    v.lr = rand_sample();
    return v;
  endfunction

  function automatic vertex_t make_vertex(input int r, input int c, input logic [31:0] s);
    vertex_t v;
    v.row = index_t'(r);
    v.col = index_t'(c);
    v.ul = sample_t'(s);
    v.ur = sample_t'(s ^ 32'h0001_3000);
    v.ll = sample_t'(s + 32'h0000_8001);
    v.lr = sample_t'(s - 32'h0002_0003);
    return v;
  endfunction

  task automatic queue_directed();
    int rows_d [9] = '{0, 0, ROWS, ROWS, 0, ROWS, 17, 40, 127};
    int cols_d [9] = '{0, COLS, 0, COLS, 21, 33, 0, COLS, 127};
    for (int i = 0; i < 9; i++) pending_vertices.push_back(make_vertex(rows_d[i], cols_d[i],
                                                           32'h0000_4000 * i));
    // behind the eye, upward and downward heights at full scale
    pending_vertices.push_back(make_vertex(32, 32, 32'h7FFF_FFFF));
    pending_vertices.push_back(make_vertex(32, 32, 32'h8000_0000));
    pending_vertices.push_back(make_vertex(0, 0, 32'h7FFF_FFFF));
    pending_vertices.push_back(make_vertex(ROWS, COLS, 32'h8000_0000));
    pending_vertices.push_back(make_vertex(32, 0, 32'h7FFF_0000));
    pending_vertices.push_back(make_vertex(ROWS / 2, COLS / 2, 32'h0));
    pending_vertices.push_back(make_vertex(100, 3, 32'hFFFF_FFFF));
    pending_vertices.push_back(make_vertex(5, 90, 32'h0000_0001));
  endtask

  task automatic load_config(input int sel);
    logic [31:0] ang [6] = '{-1800, 1800, -2048, 2047, 0, 900};
    logic [31:0] eyes [5] = '{0, 100, 10000, 16383, 1};
    int unsigned e;
    write_reg(REG_THETA, (sel % 3 == 0) ? ang[$urandom_range(0, 5)]
                                        : 32'($signed($urandom_range(0, 4095)) - 2048));
    write_reg(REG_PHI, (sel % 3 == 1) ? ang[$urandom_range(0, 5)]
                                      : 32'($signed($urandom_range(0, 4095)) - 2048));
    e = (sel % 2 == 0) ? eyes[$urandom_range(0, 4)] : $urandom_range(100, 10000);
    write_reg(REG_EYE, ($urandom_range(0, 3) == 0) ? 32'($urandom()) : e);
    write_reg(REG_X_STEP, (sel % 4 == 0) ? 32'hFFFF :
                          (sel % 4 == 1) ? 32'h0 : 32'($urandom_range(0, 2048)));
    write_reg(REG_Y_STEP, (sel % 4 == 2) ? 32'hFFFF :
                          (sel % 4 == 3) ? 32'h0 : $urandom());
    write_reg(REG_Z_GAIN, (sel % 5 == 0) ? 32'hFFFF_FFFF :
                          (sel % 5 == 1) ? 32'h0 : 32'($urandom_range(0, 262144)));
    write_reg(REG_VAL_MIN, (sel % 4 == 0) ? 32'h8000_0000 : 32'($urandom_range(0, 131072)) - 65536);
    write_reg(REG_VAL_MAX, (sel % 4 == 1) ? 32'h7FFF_FFFF :
                           (sel % 4 == 2) ? $urandom() : 32'($urandom_range(0, 262144)));
  endtask

  // sender: bursts and gaps, hold the beat until it is taken
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk) begin
    if (in_taken) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
        gap_left = $urandom_range(0, 6);
      end
    end
    if (in_bus.valid && !in_taken) begin
      // hold
    end else if (gap_left > 0) begin
      in_bus.valid <= 1'b0;
      gap_left--;
    end else if (pending_vertices.size() != 0) begin
      in_bus.valid <= 1'b1;
      in_bus.vertex_row <= pending_vertices[0].row;
      in_bus.vertex_col <= pending_vertices[0].col;
      in_bus.sample_up_left <= pending_vertices[0].ul;
      in_bus.sample_up_right <= pending_vertices[0].ur;
      in_bus.sample_low_left <= pending_vertices[0].ll;
      in_bus.sample_low_right <= pending_vertices[0].lr;
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // receiver: stall pattern plus one long hold-off on request
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left = 400;
      long_hold_req = 1'b0;
    end
    if ($urandom_range(0, 63) == 0) rx_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        default: out_bus.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // input beats become expectations; result beats are checked in order
  always @(posedge clk) begin
    point_t want;
    bit moved;
    moved = 1'b0;
    in_taken = 1'b0;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      expected_points.push_back(project_vertex(pending_vertices.pop_front()));
      n_vertices++;
      in_taken = 1'b1;
      moved = 1'b1;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      moved = 1'b1;
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_points.pop_front();
        if (out_bus.screen_x !== want.sx) report_mismatch("screen_x", out_bus.screen_x, want.sx);
        if (out_bus.screen_y !== want.sy) report_mismatch("screen_y", out_bus.screen_y, want.sy);
        if (out_bus.view_depth !== want.depth)
          report_mismatch("view_depth", out_bus.view_depth, want.depth);
        if (out_bus.behind_eye !== want.behind)
          report_mismatch("behind_eye", out_bus.behind_eye, want.behind);
        if (want.behind) n_behind++;
      end
      n_points++;
    end
    if (cfg_psel && cfg_penable) moved = 1'b1;
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    build_sine();
    for (int i = 0; i < 8; i++) shadow_write(reg_idx_t'(i), 32'h0);
    theta_sh = -300; phi_sh = 720; eye_sh = 1000; xstep_sh = 256; ystep_sh = 256;
    gain_sh = 65536; vmin_sh = 0; vmax_sh = 65536;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_directed();
    wait_drained();
    // flat view so the center column projects to exactly zero offset
    write_reg(REG_THETA, 32'h0);
    write_reg(REG_PHI, 32'h0);
    write_reg(REG_EYE, 32'd1000);
    write_reg(REG_X_STEP, 32'd256);
    write_reg(REG_Y_STEP, 32'd256);
    write_reg(REG_Z_GAIN, 32'd65536);
    write_reg(REG_VAL_MIN, 32'h0);
    write_reg(REG_VAL_MAX, 32'd65536);
    queue_directed();
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_config(ph);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) pending_vertices.push_back(rand_vertex());
      if (ph == 3) begin
        while (pending_vertices.size() > ITEMS_PER_PHASE - 5) @(posedge clk);
        long_hold_req = 1'b1;
      end
      wait_drained();
    end

    $display("covered %0d vertices, %0d points (%0d behind the eye), %0d register writes",
             n_vertices, n_points, n_behind, n_writes);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
